// ===== hdl/bfnds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfnds_pkg
// Types, register indexes, reset values and the small-count divider shared by
// the box-filtered nearest-neighbor downscaler.
// ----------------------------------------------------------------------------

package bfnds_pkg;

	// Default values for the top-level parameters.
	localparam int MAX_WIDTH_DEF = 2048;
	localparam int FRAC_BITS_DEF = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd4;

	localparam logic [11:0] SRC_WIDTH_RST  = 12'd640;
	localparam logic [11:0] SRC_HEIGHT_RST = 12'd480;
	localparam logic [23:0] STEP_RST       = 24'd65536;
	localparam logic [11:0] OUT_WIDTH_RST  = 12'd640;
	localparam logic [11:0] OUT_HEIGHT_RST = 12'd480;

	// Reciprocals: floor(x / 3) = (x * RECIP3) >> 17 and
	// floor(x / 9) = (x * RECIP9) >> 19, exact for any 12-bit x.
	localparam logic [15:0] RECIP3 = 16'd43691;
	localparam logic [15:0] RECIP9 = 16'd58255;

	typedef struct packed {
		logic [7:0] pix_c0;
		logic [7:0] pix_c1;
		logic [7:0] pix_c2;
		logic       is_fill;
	} pix_t;

	typedef struct packed {
		logic [7:0]  avg_c0;
		logic [7:0]  avg_c1;
		logic [7:0]  avg_c2;
		logic [10:0] out_col;
		logic [10:0] out_row;
		logic        frame_last;
	} res_t;

	// Truncated mean of a window sum over 0, 1, 2, 3, 4, 6 or 9 pixels.
	function automatic logic [7:0] div_by_count(input logic [11:0] sum, input logic [3:0] cnt);
		logic [27:0] p3;
		logic [27:0] p9;
		logic [7:0]  q;
		p3 = 28'(sum) * 28'(RECIP3);
		p9 = 28'(sum) * 28'(RECIP9);
		case (cnt)
			4'd1:    q = sum[7:0];
			4'd2:    q = sum[8:1];
			4'd3:    q = p3[24:17];
			4'd4:    q = sum[9:2];
			4'd6:    q = p3[25:18];
			4'd9:    q = p9[26:19];
			default: q = 8'd0;
		endcase
		return q;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/box_filtered_nearest_downscaler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_filtered_nearest_downscaler
// Downscales a raster RGB stream by nearest-neighbor pick with a 3x3 box mean.
// ----------------------------------------------------------------------------
// Source pixels enter on the pix channel in raster order, one word per cycle while pix_stall is low.
// After the W*H pixels of a frame the source sends W+1 fill words to flush
// the last row; the word that centers the window on the last source pixel
// rewinds the position counters for the next frame. Each source word yields
// zero or one result word on the res channel: the mean of the in-image 3x3
// neighborhood of the picked source pixel, with its output column and row.
// Configuration registers are written through cfg_wen/cfg_idx/cfg_data; the user
// writes them between frames, while no word is in flight; the block does not enforce this.
// An accepted source word is registered in stage 1 with its line store read;
// the window, mean and pick are formed from stage 1 into the result register.
// Throughput is one word per cycle while pix_stall is low; the line store can
// take one read and one write in the same cycle.
// When res_stall holds a finished word, at most one more source word is taken
// into stage 1, then pix_stall rises until the result register drains.
// Reset clears all position counters and loads the default geometry; the
// line stores are not cleared and are only used where a frame wrote them.
// ----------------------------------------------------------------------------

module box_filtered_nearest_downscaler #(
	parameter int MAX_WIDTH = bfnds_pkg::MAX_WIDTH_DEF,
	parameter int FRAC_BITS = bfnds_pkg::FRAC_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_wen,
	input  wire [bfnds_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire [bfnds_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                             pix_valid,
	output logic                            pix_stall,
	input  bfnds_pkg::pix_t                 pix,
	output logic                            res_valid,
	input  wire                             res_stall,
	output bfnds_pkg::res_t                 res
);

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int WW   = AW + 1;
	localparam int CW   = (WW > 12) ? WW : 12;
	localparam int ACCW = 12 + FRAC_BITS;
	localparam int SW   = ((ACCW > 24) ? ACCW : 24) + 1;

	// Saturating position accumulator add.
	function automatic logic [ACCW-1:0] acc_add(input logic [ACCW-1:0] a, input logic [23:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		if (s > SW'({ACCW{1'b1}})) begin
			return {ACCW{1'b1}};
		end
		return s[ACCW-1:0];
	endfunction

	// Configuration registers.
	logic [11:0] src_width_q, src_height_q, out_width_q, out_height_q;
	logic [23:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= bfnds_pkg::SRC_WIDTH_RST;
			src_height_q <= bfnds_pkg::SRC_HEIGHT_RST;
			step_q       <= bfnds_pkg::STEP_RST;
			out_width_q  <= bfnds_pkg::OUT_WIDTH_RST;
			out_height_q <= bfnds_pkg::OUT_HEIGHT_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				bfnds_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data[11:0];
				bfnds_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data[11:0];
				bfnds_pkg::REG_STEP:       step_q       <= cfg_data[23:0];
				bfnds_pkg::REG_OUT_WIDTH:  out_width_q  <= cfg_data[11:0];
				bfnds_pkg::REG_OUT_HEIGHT: out_height_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// Effective source geometry.
	logic [CW-1:0] sw_ext;
	logic [WW-1:0] w;
	logic [11:0]   h;

	assign sw_ext = CW'(src_width_q);
	assign h      = (src_height_q == 12'd0) ? 12'd1 : src_height_q;

	always_comb begin
		if (src_width_q == 12'd0) begin
			w = WW'(1);
		end else if (sw_ext > CW'(MAX_WIDTH)) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(sw_ext);
		end
	end

	// Handshake.
	logic s1_valid;
	logic adv;
	logic accept;
	logic s1_done;

	assign adv       = !res_valid || !res_stall;
	assign pix_stall = s1_valid && !adv;
	assign accept    = pix_valid && !pix_stall;
	assign s1_done   = s1_valid && adv;

	// Raster position of the next source word.
	logic [AW-1:0] c_q;
	logic [12:0]   r_q;
	logic          rewind_in;

	assign rewind_in = (c_q == '0) && (r_q >= 13'(h) + 13'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q      <= '0;
			r_q      <= '0;
			s1_valid <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid <= 1'b1;
				if (rewind_in) begin
					c_q <= '0;
					r_q <= '0;
				end else if (WW'(c_q) + WW'(1) >= w) begin
					c_q <= '0;
					r_q <= r_q + 13'd1;
				end else begin
					c_q <= c_q + AW'(1);
				end
			end else if (adv) begin
				s1_valid <= 1'b0;
			end
		end
	end

	// Stage 1 word and line store read data.
	logic [AW-1:0] c_s1;
	logic [12:0]   r_s1;
	logic [23:0]   pix_s1;
	logic [47:0]   line_rd_s1;
	logic          fwd_s1;
	logic [23:0]   fwd_above_s1, fwd_two_s1;
	logic [23:0]   above_eff, two_eff;

	// The line store holds {two rows above, one row above} per column.
	logic [47:0] line_mem [MAX_WIDTH];

	assign above_eff = fwd_s1 ? fwd_above_s1 : line_rd_s1[23:0];
	assign two_eff   = fwd_s1 ? fwd_two_s1   : line_rd_s1[47:24];

	always_ff @(posedge clk) begin
		if (s1_done) begin
			line_mem[c_s1] <= {above_eff, pix_s1};
		end
		if (accept) begin
			line_rd_s1 <= line_mem[c_q];
		end
	end

	// A one-column image rereads the column being written in the same cycle,
	// so the new word takes the written values directly.
	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1         <= c_q;
			r_s1         <= r_q;
			pix_s1       <= pix.is_fill ? 24'd0 : {pix.pix_c2, pix.pix_c1, pix.pix_c0};
			fwd_s1       <= s1_done && (c_s1 == c_q);
			fwd_above_s1 <= pix_s1;
			fwd_two_s1   <= above_eff;
		end
	end

	// 3x3 window, row 0 two lines up, column 2 newest.
	logic [23:0] win_q [3][3];
	logic [23:0] nwin  [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nwin[i][0] = win_q[i][1];
			nwin[i][1] = win_q[i][2];
		end
		nwin[0][2] = two_eff;
		nwin[1][2] = above_eff;
		nwin[2][2] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (s1_done) begin
			win_q <= nwin;
		end
	end

	// Window center, which trails the input by one row and one column.
	logic [AW-1:0] cx;
	logic [12:0]   cy;
	logic          center_ok;

	always_comb begin
		if (c_s1 != '0) begin
			cx        = c_s1 - AW'(1);
			cy        = r_s1 - 13'd1;
			center_ok = (r_s1 >= 13'd1);
		end else begin
			cx        = AW'(w - WW'(1));
			cy        = r_s1 - 13'd2;
			center_ok = (r_s1 >= 13'd2);
		end
	end

	// Which neighbors lie inside the source image.
	logic [2:0] row_in, col_in;
	logic [1:0] n_rows, n_cols;
	logic [3:0] cnt;

	assign row_in[0] = (cy != 13'd0);
	assign row_in[1] = (cy < 13'(h));
	assign row_in[2] = (cy + 13'd1 < 13'(h));
	assign col_in[0] = (cx != '0);
	assign col_in[1] = (WW'(cx) < w);
	assign col_in[2] = (WW'(cx) + WW'(1) < w);

	assign n_rows = 2'(row_in[0]) + 2'(row_in[1]) + 2'(row_in[2]);
	assign n_cols = 2'(col_in[0]) + 2'(col_in[1]) + 2'(col_in[2]);
	assign cnt    = 4'(n_rows) * 4'(n_cols);

	logic [11:0] sum [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum[k] = 12'd0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (row_in[i] && col_in[j]) begin
						sum[k] = sum[k] + 12'(nwin[i][j][8*k +: 8]);
					end
				end
			end
		end
	end

	// Output position counters and source targets.
	logic [11:0]     ocol_q, orow_q;
	logic [ACCW-1:0] acc_x_q, acc_y_q;
	logic [CW-1:0]   tx_ext, tx_cl, w_m1;
	logic [AW-1:0]   tx;
	logic [11:0]     ty_raw, ty;
	logic            hit;
	logic            emit;
	logic            rewind_s1;

	assign w_m1   = CW'(w) - CW'(1);
	assign tx_ext = CW'(acc_x_q[ACCW-1:FRAC_BITS]);
	assign tx_cl  = (tx_ext > w_m1) ? w_m1 : tx_ext;
	assign tx     = tx_cl[AW-1:0];
	assign ty_raw = acc_y_q[ACCW-1:FRAC_BITS];
	assign ty     = (ty_raw > h - 12'd1) ? (h - 12'd1) : ty_raw;

	// The target has been reached once the center is at or past it in raster order.
	assign hit  = (13'(ty) < cy) || ((13'(ty) == cy) && (tx <= cx));
	assign emit = center_ok && (ocol_q < out_width_q) && (orow_q < out_height_q) && hit;

	assign rewind_s1 = (c_s1 == '0) && (r_s1 >= 13'(h) + 13'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocol_q  <= '0;
			orow_q  <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (s1_done) begin
			if (rewind_s1) begin
				ocol_q  <= '0;
				orow_q  <= '0;
				acc_x_q <= '0;
				acc_y_q <= '0;
			end else if (emit) begin
				if (13'(ocol_q) + 13'd1 >= 13'(out_width_q)) begin
					ocol_q  <= '0;
					orow_q  <= orow_q + 12'd1;
					acc_x_q <= '0;
					acc_y_q <= acc_add(acc_y_q, step_q);
				end else begin
					ocol_q  <= ocol_q + 12'd1;
					acc_x_q <= acc_add(acc_x_q, step_q);
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= s1_valid && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done && emit) begin
			res.avg_c0     <= bfnds_pkg::div_by_count(sum[0], cnt);
			res.avg_c1     <= bfnds_pkg::div_by_count(sum[1], cnt);
			res.avg_c2     <= bfnds_pkg::div_by_count(sum[2], cnt);
			res.out_col    <= ocol_q[10:0];
			res.out_row    <= orow_q[10:0];
			res.frame_last <= (ocol_q == out_width_q - 12'd1) &&
				(orow_q == out_height_q - 12'd1);
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_box_filtered_nearest_downscaler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_box_filtered_nearest_downscaler
// Self-checking bench for the box-filtered nearest-neighbor downscaler.
// ----------------------------------------------------------------------------
// Whole source frames are streamed through the pix channel under random
// sender gaps and receiver stalls. A scoreboard keeps its own line stores,
// 3x3 window and position accumulators, predicts each downscaled pixel as
// words are accepted and compares every result word field by field.
// Geometry is reprogrammed only between complete frames. A short directed
// pass covers corners, edges, fills, clamped targets and flush pixels; fixed
// extreme geometries follow, then random small frames.
// ----------------------------------------------------------------------------

module tb_box_filtered_nearest_downscaler;

	class downscale_board;
		logic [11:0] src_w, src_h, out_w, out_h;
		logic [23:0] step;
		logic [23:0] row_above [bfnds_pkg::MAX_WIDTH_DEF];
		logic [23:0] row_two_above [bfnds_pkg::MAX_WIDTH_DEF];
		logic [23:0] win [3][3];
		int unsigned in_col, in_row, col_cnt, row_cnt;
		longint unsigned acc_x, acc_y;
		bfnds_pkg::res_t awaited_pixels [$];
		int errors;
		int checked;

		function new();
			src_w = bfnds_pkg::SRC_WIDTH_RST;
			src_h = bfnds_pkg::SRC_HEIGHT_RST;
			step  = bfnds_pkg::STEP_RST;
			out_w = bfnds_pkg::OUT_WIDTH_RST;
			out_h = bfnds_pkg::OUT_HEIGHT_RST;
			foreach (row_above[i]) begin
				row_above[i]     = '0;
				row_two_above[i] = '0;
			end
			foreach (win[i, j]) win[i][j] = '0;
			errors  = 0;
			checked = 0;
			rewind();
		endfunction

		function void rewind();
			in_col  = 0;
			in_row  = 0;
			col_cnt = 0;
			row_cnt = 0;
			acc_x   = 0;
			acc_y   = 0;
		endfunction

		function int pending();
			return awaited_pixels.size();
		endfunction

		function void set_register(logic [bfnds_pkg::CFG_IDX_W-1:0] idx,
			logic [bfnds_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				bfnds_pkg::REG_SRC_WIDTH:  src_w = data[11:0];
				bfnds_pkg::REG_SRC_HEIGHT: src_h = data[11:0];
				bfnds_pkg::REG_STEP:       step  = data;
				bfnds_pkg::REG_OUT_WIDTH:  out_w = data[11:0];
				bfnds_pkg::REG_OUT_HEIGHT: out_h = data[11:0];
				default: ;
			endcase
		endfunction

		// The position accumulators stop at the top of their 12.16 range.
		function longint unsigned sat_add(longint unsigned a);
			longint unsigned lim;
			longint unsigned s;
			lim = (longint'(4096) << bfnds_pkg::FRAC_BITS_DEF) - 1;
			s = a + step;
			return (s > lim) ? lim : s;
		endfunction

		function void take_pixel(bfnds_pkg::pix_t p);
			int w, h, c, r, col, cnt, i, j, k;
			longint cx, cy, tx, ty, yy, xx;
			bit centered;
			logic [23:0] val;
			int unsigned sum [3];
			bfnds_pkg::res_t e;
			w = (src_w == 0) ? 1 : ((src_w > bfnds_pkg::MAX_WIDTH_DEF) ?
				bfnds_pkg::MAX_WIDTH_DEF : int'(src_w));
			h = (src_h == 0) ? 1 : int'(src_h);
			c = in_col;
			r = in_row;
			val = p.is_fill ? 24'd0 : {p.pix_c2, p.pix_c1, p.pix_c0};
			col = c % bfnds_pkg::MAX_WIDTH_DEF;
			for (i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = row_two_above[col];
			win[1][2] = row_above[col];
			win[2][2] = val;
			row_two_above[col] = row_above[col];
			row_above[col] = val;

			// The window center trails the input by one row and one column.
			if (c >= 1) begin
				cx = c - 1;
				cy = r - 1;
				centered = (r >= 1);
			end else begin
				cx = w - 1;
				cy = r - 2;
				centered = (r >= 2);
			end

			if (centered && col_cnt < out_w && row_cnt < out_h) begin
				tx = longint'(acc_x >> bfnds_pkg::FRAC_BITS_DEF);
				ty = longint'(acc_y >> bfnds_pkg::FRAC_BITS_DEF);
				if (tx > w - 1) tx = w - 1;
				if (ty > h - 1) ty = h - 1;
				if (ty < cy || (ty == cy && tx <= cx)) begin
					sum = '{0, 0, 0};
					cnt = 0;
					for (i = 0; i < 3; i++) begin
						yy = cy - 1 + i;
						if (yy < 0 || yy >= h) continue;
						for (j = 0; j < 3; j++) begin
							xx = cx - 1 + j;
							if (xx < 0 || xx >= w) continue;
							for (k = 0; k < 3; k++) sum[k] += win[i][j][8*k +: 8];
							cnt++;
						end
					end
					e.avg_c0     = (cnt != 0) ? 8'(sum[0] / cnt) : 8'd0;
					e.avg_c1     = (cnt != 0) ? 8'(sum[1] / cnt) : 8'd0;
					e.avg_c2     = (cnt != 0) ? 8'(sum[2] / cnt) : 8'd0;
					e.out_col    = 11'(col_cnt);
					e.out_row    = 11'(row_cnt);
					e.frame_last = (col_cnt == out_w - 1) && (row_cnt == out_h - 1);
					awaited_pixels.push_back(e);
					if (col_cnt + 1 >= out_w) begin
						col_cnt = 0;
						row_cnt++;
						acc_x = 0;
						acc_y = sat_add(acc_y);
					end else begin
						col_cnt++;
						acc_x = sat_add(acc_x);
					end
				end
			end

			if (c == 0 && r >= h + 1) begin
				rewind();
			end else if (c + 1 >= w) begin
				in_col = 0;
				in_row = r + 1;
			end else begin
				in_col = c + 1;
			end
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		task check_result(bfnds_pkg::res_t got);
			bfnds_pkg::res_t want;
			if (awaited_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected word at (%0d,%0d)", got.out_col,
					got.out_row));
				return;
			end
			want = awaited_pixels.pop_front();
			checked++;
			if (got.avg_c0 !== want.avg_c0)
				report_mismatch($sformatf("avg_c0 at (%0d,%0d): got %0d, want %0d",
					want.out_col, want.out_row, got.avg_c0, want.avg_c0));
			if (got.avg_c1 !== want.avg_c1)
				report_mismatch($sformatf("avg_c1 at (%0d,%0d): got %0d, want %0d",
					want.out_col, want.out_row, got.avg_c1, want.avg_c1));
			if (got.avg_c2 !== want.avg_c2)
				report_mismatch($sformatf("avg_c2 at (%0d,%0d): got %0d, want %0d",
					want.out_col, want.out_row, got.avg_c2, want.avg_c2));
			if (got.out_col !== want.out_col)
				report_mismatch($sformatf("out_col: got %0d, want %0d", got.out_col,
					want.out_col));
			if (got.out_row !== want.out_row)
				report_mismatch($sformatf("out_row: got %0d, want %0d", got.out_row,
					want.out_row));
			if (got.frame_last !== want.frame_last)
				report_mismatch($sformatf("frame_last at (%0d,%0d): got %0b, want %0b",
					want.out_col, want.out_row, got.frame_last, want.frame_last));
		endtask
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_wen;
	logic [bfnds_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [bfnds_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                             pix_valid;
	logic                             pix_stall;
	bfnds_pkg::pix_t                  pix_word;
	logic                             res_valid;
	logic                             res_stall;
	bfnds_pkg::res_t                  res_word;

	downscale_board sb = new();
	int words_sent;
	int frames_run;

	box_filtered_nearest_downscaler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res_word)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("[box_filtered_nearest_downscaler] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
			sb.check_result(res_word);
	end

	// Receiver: runs of free cycles broken by stalls, mostly short.
	initial begin : res_side
		int free_len;
		int stall_len;
		int roll;
		res_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			roll = $urandom_range(0, 99);
			if (roll < 40) free_len = $urandom_range(1, 2);
			else if (roll < 80) free_len = $urandom_range(3, 8);
			else if (roll < 95) free_len = $urandom_range(20, 60);
			else free_len = $urandom_range(100, 300);
			roll = $urandom_range(0, 99);
			if (roll < 85) stall_len = $urandom_range(1, 3);
			else if (roll < 97) stall_len = $urandom_range(4, 12);
			else stall_len = $urandom_range(60, 150);
			repeat (free_len) @(negedge clk);
			res_stall <= 1'b1;
			repeat (stall_len) @(negedge clk);
			res_stall <= 1'b0;
		end
	end

	function automatic logic [7:0] rand_chan();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return 8'd0;
		if (roll == 1) return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic bfnds_pkg::pix_t make_word(logic [7:0] a, logic [7:0] b,
		logic [7:0] c, logic fill);
		bfnds_pkg::pix_t p;
		p.pix_c0  = a;
		p.pix_c1  = b;
		p.pix_c2  = c;
		p.is_fill = fill;
		return p;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Wait until every predicted word has drained, then let the pipe go quiet.
	task automatic settle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [bfnds_pkg::CFG_IDX_W-1:0] idx,
		logic [bfnds_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wen  <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_register(idx, data);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic set_geometry(int w, int h, int step, int ow, int oh);
		settle();
		write_reg(bfnds_pkg::REG_SRC_WIDTH, bfnds_pkg::CFG_DATA_W'(w));
		write_reg(bfnds_pkg::REG_SRC_HEIGHT, bfnds_pkg::CFG_DATA_W'(h));
		write_reg(bfnds_pkg::REG_STEP, bfnds_pkg::CFG_DATA_W'(step));
		write_reg(bfnds_pkg::REG_OUT_WIDTH, bfnds_pkg::CFG_DATA_W'(ow));
		write_reg(bfnds_pkg::REG_OUT_HEIGHT, bfnds_pkg::CFG_DATA_W'(oh));
	endtask

	// A hold drains every outstanding result before the word is offered.
	task automatic send(bfnds_pkg::pix_t word, int gap, bit hold);
		@(negedge clk);
		if (hold || gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
			if (hold) begin
				do @(negedge clk); while (sb.pending() != 0);
			end
		end
		pix_valid <= 1'b1;
		pix_word  <= word;
		do @(posedge clk); while (pix_stall !== 1'b0);
		sb.take_pixel(word);
		words_sent++;
	endtask

	// One complete frame plus its flush. Noisy frames slip fills into the
	// picture and real pixels into the flush.
	task automatic run_frame(int w, int h, bit noisy);
		int total;
		int k;
		bit calm;
		bfnds_pkg::pix_t word;
		total = w * h + w + 1;
		calm = ($urandom_range(0, 3) == 0);
		for (k = 0; k < total; k++) begin
			if (k < w * h)
				word = make_word(rand_chan(), rand_chan(), rand_chan(),
					noisy && $urandom_range(0, 24) == 0);
			else
				word = make_word(rand_chan(), rand_chan(), rand_chan(),
					!(noisy && $urandom_range(0, 7) == 0));
			send(word, calm ? 0 : pick_gap(), $urandom_range(0, 199) == 0);
		end
		@(negedge clk);
		pix_valid <= 1'b0;
		frames_run++;
	endtask

	initial begin : main
		bfnds_pkg::pix_t seq [$];
		int random_words;
		int w, h, step, ow, oh, nf, f, roll;
		arst_n     = 1'b0;
		cfg_wen    = 1'b0;
		cfg_idx    = '0;
		cfg_data   = '0;
		pix_valid  = 1'b0;
		pix_word   = '0;
		words_sent = 0;
		frames_run = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 3x3 at unit scale: corners, edges and the interior, a fill in the
		// middle of the picture and a real pixel inside the flush.
		set_geometry(3, 3, 65536, 3, 3);
		seq.push_back(make_word(8'd255, 8'd255, 8'd255, 1'b0));
		seq.push_back(make_word(8'd0, 8'd0, 8'd0, 1'b0));
		seq.push_back(make_word(8'd255, 8'd0, 8'd255, 1'b0));
		seq.push_back(make_word(8'd0, 8'd255, 8'd0, 1'b0));
		seq.push_back(make_word(8'd77, 8'd88, 8'd99, 1'b1));
		seq.push_back(make_word(8'd255, 8'd255, 8'd255, 1'b0));
		seq.push_back(make_word(8'd1, 8'd2, 8'd3, 1'b0));
		seq.push_back(make_word(8'd254, 8'd253, 8'd252, 1'b0));
		seq.push_back(make_word(8'd255, 8'd255, 8'd255, 1'b0));
		seq.push_back(make_word(8'd0, 8'd0, 8'd0, 1'b1));
		seq.push_back(make_word(8'd200, 8'd200, 8'd200, 1'b0));
		seq.push_back(make_word(8'd255, 8'd255, 8'd255, 1'b1));
		seq.push_back(make_word(8'd0, 8'd0, 8'd0, 1'b1));
		foreach (seq[k]) send(seq[k], pick_gap(), k == 6);
		@(negedge clk);
		pix_valid <= 1'b0;
		frames_run++;

		// More output columns than source columns: clamped targets lag and the
		// ones still owed at the frame end are dropped.
		set_geometry(2, 2, 65536, 3, 2);
		run_frame(2, 2, 1'b0);

		set_geometry(1, 1, 65536, 1, 1);
		repeat (3) run_frame(1, 1, 1'b1);
		// Largest step: the column and then the row accumulator saturate.
		set_geometry(4, 8, 24'hFFFFFF, 40, 2);
		run_frame(4, 8, 1'b0);
		set_geometry(24, 4, 24'hFFFFFF, 1, 40);
		run_frame(24, 4, 1'b0);
		set_geometry(5, 3, 65536, 2048, 2048);
		run_frame(5, 3, 1'b1);

		random_words = 0;
		while (random_words < 520) begin
			w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
			h = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
			roll = $urandom_range(0, 99);
			if (roll < 20) step = 65536;
			else if (roll < 55) step = $urandom_range(65537, 4 * 65536);
			else if (roll < 75) step = 65536 * $urandom_range(2, 4);
			else step = $urandom_range(65536, 24'hFFFFFF);
			ow = int'((longint'(w) << 16) / step);
			oh = int'((longint'(h) << 16) / step);
			if (ow == 0 || $urandom_range(0, 3) == 0) ow = $urandom_range(1, w + 3);
			if (oh == 0 || $urandom_range(0, 3) == 0) oh = $urandom_range(1, h + 3);
			set_geometry(w, h, step, ow, oh);
			nf = $urandom_range(1, 3);
			for (f = 0; f < nf && random_words < 520; f++) begin
				run_frame(w, h, $urandom_range(0, 2) != 0);
				random_words += w * h + w + 1;
			end
		end

		settle();
		$display("Streamed %0d source words in %0d frames; %0d downscaled pixels compared.",
			words_sent, frames_run, sb.checked);
		$display("Geometries ran from 1x1 up to 24 wide or 12 tall, steps from 1.0 to the maximum.");
		if (sb.errors == 0) begin
			$display("[box_filtered_nearest_downscaler] OK");
		end else begin
			$display("[box_filtered_nearest_downscaler] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== box_filtered_nearest_downscaler.f =====
hdl/bfnds_pkg.sv
hdl/box_filtered_nearest_downscaler.sv
bench/tb_box_filtered_nearest_downscaler.sv
